// ===== hdl/hcls_pkg.sv =====
package hcls_pkg;

    // Default width of the length arithmetic; the cap is never wider than 32 bits.
    localparam int DEF_LENGTH_BITS = 32;

    // The header name that introduces the content length, including its colon.
    localparam int KEY_LEN = 15;
    localparam logic [7:0] KEY_TEXT [KEY_LEN] = '{
        8'h43, 8'h6F, 8'h6E, 8'h74, 8'h65, 8'h6E, 8'h74, 8'h2D,
        8'h4C, 8'h65, 8'h6E, 8'h67, 8'h74, 8'h68, 8'h3A
    };

    // Characters with a meaning of their own.
    localparam logic [7:0] CHR_NUL   = 8'h00;
    localparam logic [7:0] CHR_LF    = 8'h0A;
    localparam logic [7:0] CHR_CR    = 8'h0D;
    localparam logic [7:0] CHR_SPACE = 8'h20;
    localparam logic [7:0] CHR_ZERO  = 8'h30;
    localparam logic [7:0] CHR_NINE  = 8'h39;

    // Line length saturates at the top of its 16-bit counter.
    localparam logic [15:0] POS_MAX = 16'hFFFF;

    // Parsing phase of the current line.
    typedef enum logic [4:0] {
        PH_TOKEN = 5'b00001,
        PH_SKIP  = 5'b00010,
        PH_VALUE = 5'b00100,
        PH_VDONE = 5'b01000,
        PH_DONE  = 5'b10000
    } t_phase;

    // Request payload: one response byte.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    // Result payload.
    typedef struct packed {
        logic [31:0] total_length;
        logic        length_found;
        logic        header_complete;
    } t_out_item;

endpackage

// ===== hdl/hcls_in_if.sv =====
interface hcls_in_if
    import hcls_pkg::*;
();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/hcls_out_if.sv =====
interface hcls_out_if
    import hcls_pkg::*;
();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/http_content_length_scanner.sv =====
// A result goes from the byte that ends the scan through the snapshot stage into the output register.
// Throughput: one byte per cycle while the result stages do not hold back i_in.ready.
// Bytes that cause no result give nothing; a result stage frees as soon as it is taken.
// Reset: synchronous, active low on i_rst_n; it clears the scan state and both result stages.
// A byte marked last also returns the scan state to its reset values.
module http_content_length_scanner
    import hcls_pkg::*;
#(
    parameter int LENGTH_BITS = DEF_LENGTH_BITS
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    hcls_in_if.sink    i_in,
    hcls_out_if.source o_out
);

    // Saturation limit: the smaller of 2^LENGTH_BITS - 1 and 2^32 - 1.
    localparam logic [63:0] CAP64 = (LENGTH_BITS >= 32) ? 64'hFFFF_FFFF
                                  : ((64'd1 << LENGTH_BITS) - 64'd1);
    localparam logic [31:0] CAP   = CAP64[31:0];

    // State of the line being parsed.
    typedef struct packed {
        t_phase      phase;
        logic        match;
        logic [31:0] acc;
        logic [15:0] pos;
    } t_line;

    // Saturating add of a header count and an increment.
    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > {1'b0, CAP}) ? CAP : s[31:0];
    endfunction

    // One ordinary byte of a line.
    function automatic t_line feed(input t_line s, input logic [7:0] b);
        t_line       r;
        logic [35:0] v;
        r = s;
        v = '0;
        unique case (s.phase)
            PH_TOKEN: begin
                if (b == CHR_SPACE) begin
                    r.phase = (s.match && s.pos == 16'(KEY_LEN)) ? PH_VALUE : PH_SKIP;
                    r.acc   = '0;
                end else if (s.pos >= 16'(KEY_LEN) || b != KEY_TEXT[s.pos[3:0]]) begin
                    r.match = 1'b0;
                end
            end
            PH_VALUE: begin
                if (b == CHR_SPACE) begin
                    r.phase = PH_VDONE;
                end else if (b >= CHR_ZERO && b <= CHR_NINE) begin
                    v = {1'b0, s.acc, 3'b000} + {3'b000, s.acc, 1'b0}
                      + {28'd0, 8'(b - CHR_ZERO)};
                    r.acc = (v > {4'd0, CAP}) ? CAP : v[31:0];
                end
            end
            default: begin
            end
        endcase
        if (s.pos < POS_MAX) begin
            r.pos = s.pos + 16'd1;
        end
        return r;
    endfunction

    localparam t_line LINE_INIT = '{phase: PH_TOKEN, match: 1'b1, acc: '0, pos: '0};

    // Scan state.
    t_line       r_line,   n_line;
    logic [31:0] r_hdr,    n_hdr;
    logic [31:0] r_cl,     n_cl;
    logic        r_found,  n_found;
    logic        r_pend,   n_pend;

    // Snapshot stage and output stage.
    logic        r_a_valid;
    logic [31:0] r_a_hdr,  n_a_hdr;
    logic [31:0] r_a_cl,   n_a_cl;
    logic        r_a_found, n_a_found;
    logic        r_a_cmp,  n_a_cmp;
    logic        r_o_valid;
    t_out_item   r_o_item;

    logic        w_accept;
    logic        w_result;
    logic        w_adv_a;
    logic        w_adv_o;
    logic [32:0] w_total;

    // Pipeline advance: a stage moves when it is empty or its successor moves.
    assign w_adv_o   = !r_o_valid || o_out.ready;
    assign w_adv_a   = !r_a_valid || w_adv_o;
    assign i_in.ready = w_adv_a;
    assign w_accept  = i_in.valid && w_adv_a;

    // Next scan state for the accepted byte.
    always_comb begin
        logic [7:0] b;
        logic       last;
        logic       emit;
        b         = i_in.data.data_byte;
        last      = i_in.data.last_byte;
        emit      = 1'b0;
        n_line    = r_line;
        n_hdr     = r_hdr;
        n_cl      = r_cl;
        n_found   = r_found;
        n_pend    = r_pend;
        w_result  = 1'b0;
        n_a_hdr   = r_a_hdr;
        n_a_cl    = r_a_cl;
        n_a_found = r_a_found;
        n_a_cmp   = 1'b0;
        if (w_accept) begin
            if (r_line.phase == PH_DONE) begin
                // After the result, bytes are dropped until the last one.
                if (last) begin
                    n_line  = LINE_INIT;
                    n_hdr   = '0;
                    n_cl    = '0;
                    n_found = 1'b0;
                    n_pend  = 1'b0;
                end
            end else begin
                priority if (b == CHR_NUL) begin
                    emit = 1'b1;
                end else if (r_pend && b == CHR_LF) begin
                    // Line ended by CR LF; an empty line ends the header.
                    n_pend = 1'b0;
                    if (r_line.pos == '0) begin
                        n_hdr   = sat_add(r_hdr, 32'd2);
                        emit    = 1'b1;
                        n_a_cmp = 1'b1;
                    end else begin
                        if (r_line.phase == PH_VALUE || r_line.phase == PH_VDONE) begin
                            n_cl    = r_line.acc;
                            n_found = 1'b1;
                        end else if (r_line.phase == PH_TOKEN && r_line.match
                                     && r_line.pos == 16'(KEY_LEN)) begin
                            n_cl    = '0;
                            n_found = 1'b1;
                        end
                        n_hdr  = sat_add(r_hdr, 32'(r_line.pos) + 32'd2);
                        n_line = LINE_INIT;
                    end
                end else if (r_pend) begin
                    // A CR without its LF is an ordinary byte.
                    n_line = feed(r_line, CHR_CR);
                    if (b == CHR_CR) begin
                        n_pend = 1'b1;
                    end else begin
                        n_pend = 1'b0;
                        n_line = feed(n_line, b);
                    end
                end else if (b == CHR_CR) begin
                    n_pend = 1'b1;
                end else begin
                    n_line = feed(r_line, b);
                end
                if (emit || last) begin
                    w_result  = 1'b1;
                    n_a_hdr   = n_hdr;
                    n_a_cl    = n_cl;
                    n_a_found = n_found;
                    if (last) begin
                        n_line  = LINE_INIT;
                        n_hdr   = '0;
                        n_cl    = '0;
                        n_found = 1'b0;
                        n_pend  = 1'b0;
                    end else begin
                        n_line.phase = PH_DONE;
                    end
                end
            end
        end
    end

    // Scan state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line  <= LINE_INIT;
            r_hdr   <= '0;
            r_cl    <= '0;
            r_found <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_line  <= n_line;
            r_hdr   <= n_hdr;
            r_cl    <= n_cl;
            r_found <= n_found;
            r_pend  <= n_pend;
        end
    end

    // Snapshot stage holds the counts of a finished scan.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_adv_a) begin
            r_a_valid <= w_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_result) begin
            r_a_hdr   <= n_a_hdr;
            r_a_cl    <= n_a_cl;
            r_a_found <= n_a_found;
            r_a_cmp   <= n_a_cmp;
        end
    end

    // Total length, capped; without a content length it is the cap itself.
    assign w_total = {1'b0, r_a_hdr} + {1'b0, r_a_cl};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_adv_o) begin
            r_o_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv_o && r_a_valid) begin
            r_o_item.total_length    <= !r_a_found ? CAP
                                      : (w_total > {1'b0, CAP}) ? CAP : w_total[31:0];
            r_o_item.length_found    <= r_a_found;
            r_o_item.header_complete <= r_a_cmp;
        end
    end

    assign o_out.valid = r_o_valid;
    assign o_out.data  = r_o_item;

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import hcls_pkg::*;

    localparam int LEN_BITS = DEF_LENGTH_BITS;
    localparam logic [31:0] LEN_CAP = (LEN_BITS >= 32) ? 32'hFFFF_FFFF
                                                       : 32'((64'd1 << LEN_BITS) - 64'd1);
    localparam int NUM_ROWS       = 21;
    localparam int RANDOM_BYTES   = 750;
    localparam int MIN_RAND_SCANS = 12;
    localparam int HOLD_CYCLES    = 300;
    localparam int BURST_SCANS    = 40;
    localparam int QUIET_LIMIT    = 3000;
    localparam int DRAIN_CYCLES   = 8;

    // One directed scan: optional run of filler bytes, the text, an optional NUL.
    typedef struct {
        string       txt;
        int unsigned pad;
        bit          nul_end;
        bit          last_end;
        bit          typed;
        t_out_item   want;
    } t_scan_row;

    logic i_clk;
    logic i_rst_n;

    hcls_in_if  in_if ();
    hcls_out_if out_if ();

    http_content_length_scanner #(.LENGTH_BITS(LEN_BITS)) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    // Shadow copy of the scanner state.
    logic [31:0] hdr_bytes;
    logic [15:0] line_len;
    t_phase      phase;
    logic        key_ok;
    logic [31:0] acc;
    logic [31:0] clen;
    logic        seen_len;
    logic        cr_wait;

    t_out_item   pending_results [$];
    t_scan_row   scan_rows [NUM_ROWS];

    int  failures      = 0;
    int  results_due   = 0;
    int  results_seen  = 0;
    int  bytes_sent    = 0;
    int  scans_sent    = 0;
    int  tx_idle_pct   = 0;
    int  rx_idle_pct   = 0;
    int  quiet_cycles  = 0;
    bit  stall_request = 1'b0;
    bit  run_done      = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Length addition that saturates at the cap.
    function automatic logic [31:0] cap_add(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        return (s > 64'(LEN_CAP)) ? LEN_CAP : s[31:0];
    endfunction

    function automatic void clear_line();
        line_len = '0;
        phase    = PH_TOKEN;
        key_ok   = 1'b1;
        acc      = '0;
    endfunction

    function automatic void restart_scan();
        hdr_bytes = '0;
        clen      = '0;
        seen_len  = 1'b0;
        cr_wait   = 1'b0;
        clear_line();
    endfunction

    // One character of a line: token matching, then value digits.
    function automatic void feed_char(input logic [7:0] c);
        logic [63:0] v;
        if (phase == PH_TOKEN) begin
            if (c == CHR_SPACE) begin
                phase = (key_ok && line_len == KEY_LEN) ? PH_VALUE : PH_SKIP;
                acc   = '0;
            end else if (line_len >= KEY_LEN || c != KEY_TEXT[line_len]) begin
                key_ok = 1'b0;
            end
        end else if (phase == PH_VALUE) begin
            if (c == CHR_SPACE) begin
                phase = PH_VDONE;
            end else if (c >= CHR_ZERO && c <= CHR_NINE) begin
                v   = 64'(acc) * 64'd10 + 64'(c - CHR_ZERO);
                acc = (v > 64'(LEN_CAP)) ? LEN_CAP : v[31:0];
            end
        end
        if (line_len != POS_MAX) begin
            line_len = line_len + 16'd1;
        end
    endfunction

    // Advances the shadow state by one request; returns 1 when a result is due.
    function automatic bit scan_byte(input logic [7:0] b, input logic lst,
                                     output t_out_item res);
        bit emit;
        bit complete;
        emit     = 1'b0;
        complete = 1'b0;
        res      = '0;
        if (phase == PH_DONE) begin
            if (lst) begin
                restart_scan();
            end
            return 1'b0;
        end
        if (b == CHR_NUL) begin
            emit = 1'b1;
        end else if (cr_wait) begin
            if (b == CHR_LF) begin
                cr_wait = 1'b0;
                if (line_len == 0) begin
                    hdr_bytes = cap_add(64'(hdr_bytes), 64'd2);
                    emit      = 1'b1;
                    complete  = 1'b1;
                end else begin
                    // A completed line may commit its content length.
                    if (phase == PH_VALUE || phase == PH_VDONE) begin
                        clen     = acc;
                        seen_len = 1'b1;
                    end else if (phase == PH_TOKEN && key_ok && line_len == KEY_LEN) begin
                        clen     = '0;
                        seen_len = 1'b1;
                    end
                    hdr_bytes = cap_add(64'(hdr_bytes), 64'(line_len) + 64'd2);
                    clear_line();
                end
            end else begin
                // The held CR was an ordinary byte after all.
                feed_char(CHR_CR);
                if (b != CHR_CR) begin
                    cr_wait = 1'b0;
                    feed_char(b);
                end
            end
        end else if (b == CHR_CR) begin
            cr_wait = 1'b1;
        end else begin
            feed_char(b);
        end
        if (!emit && !lst) begin
            return 1'b0;
        end
        res.total_length    = seen_len ? cap_add(64'(hdr_bytes), 64'(clen)) : LEN_CAP;
        res.length_found    = seen_len;
        res.header_complete = complete;
        if (lst) begin
            restart_scan();
        end else begin
            phase = PH_DONE;
        end
        return 1'b1;
    endfunction

    function automatic void add_text(ref logic [7:0] q [$], input string s);
        for (int k = 0; k < s.len(); k++) begin
            q.push_back(s[k]);
        end
    endfunction

    // Decimal text for a value field, sometimes oversized, empty or with stray characters.
    function automatic string value_text();
        string s;
        case ($urandom_range(9))
            0: s = $sformatf("%0d%0d", $urandom, $urandom);
            1: s = $sformatf("%0d", $urandom);
            2: begin
                s = $sformatf("%0d", $urandom_range(99999));
                s = {s.substr(0, 0), "x", s.substr(1, s.len() - 1)};
            end
            3: s = "";
            default: s = $sformatf("%0d", $urandom_range(9999));
        endcase
        return s;
    endfunction

    // Builds one random response; most are well formed, the rest noise.
    function automatic void build_scan(ref logic [7:0] q [$]);
        string key;
        int    n;
        q.delete();
        if ($urandom_range(99) < 20) begin
            repeat ($urandom_range(1, 24)) q.push_back(8'($urandom_range(255)));
            return;
        end
        if ($urandom_range(3) != 0) begin
            add_text(q, "HTTP/1.1 200 OK\015\012");
        end
        repeat ($urandom_range(3)) begin
            case ($urandom_range(5))
                0, 1: add_text(q, {"Content-Length: ", value_text(), "\015\012"});
                2: add_text(q, {"Content-Length: ", value_text(), " ", value_text(),
                                "\015\012"});
                3: add_text(q, "Content-Length:\015\012");
                4: begin
                    // A key that is close to the real one and usually not equal.
                    key = "Content-Length:";
                    case ($urandom_range(2))
                        0: key[$urandom_range(14)] = 8'($urandom_range(33, 126));
                        1: key = key.substr(0, $urandom_range(13));
                        default: key = {key, ":"};
                    endcase
                    add_text(q, {key, " ", value_text(), "\015\012"});
                end
                default: begin
                    n = $urandom_range(12);
                    repeat (n) begin
                        if ($urandom_range(99) < 15) begin
                            q.push_back(8'($urandom_range(1, 255)));
                        end else begin
                            q.push_back(8'($urandom_range(32, 126)));
                        end
                    end
                    add_text(q, "\015\012");
                end
            endcase
        end
        case ($urandom_range(9))
            7: begin
                q.push_back(CHR_NUL);
                repeat ($urandom_range(2)) q.push_back(8'($urandom_range(255)));
            end
            8: ;
            9: add_text(q, "\015\012");
            default: begin
                add_text(q, "\015\012");
                repeat ($urandom_range(4)) q.push_back(8'($urandom_range(255)));
                q.push_back(8'h7A);
            end
        endcase
        if (q.size() == 0) begin
            q.push_back(8'($urandom_range(255)));
        end
    endfunction

    // Offers one request after a random gap and records what it should produce.
    task automatic send_byte(input logic [7:0] b, input logic lst,
                             input bit use_typed, input t_out_item typed);
        t_out_item got;
        while ($urandom_range(99) < tx_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= '{data_byte: b, last_byte: lst};
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        bytes_sent++;
        if (scan_byte(b, lst, got)) begin
            pending_results.push_back(use_typed ? typed : got);
            results_due++;
        end
    endtask

    // Result receiver, with an occasional long hold-off.
    initial begin
        int hold_left;
        hold_left = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else if (stall_request) begin
                stall_request = 1'b0;
                hold_left     = HOLD_CYCLES;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Compare every accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("unexpected result: total_length %0d", out_if.data.total_length);
                failures++;
            end else begin
                want = pending_results.pop_front();
                if (out_if.data.total_length !== want.total_length) begin
                    $error("total_length: expected %0d, got %0d",
                           want.total_length, out_if.data.total_length);
                    failures++;
                end
                if (out_if.data.length_found !== want.length_found) begin
                    $error("length_found: expected %0b, got %0b",
                           want.length_found, out_if.data.length_found);
                    failures++;
                end
                if (out_if.data.header_complete !== want.header_complete) begin
                    $error("header_complete: expected %0b, got %0b",
                           want.header_complete, out_if.data.header_complete);
                    failures++;
                end
            end
        end
    end

    // Watchdog on cycles in which neither side moves anything.
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
        end
        if (!run_done && quiet_cycles >= QUIET_LIMIT) begin
            $display("Timeout: no handshake for %0d cycles, %0d results outstanding.",
                     quiet_cycles, pending_results.size());
            $display("[http_content_length_scanner] ERROR");
            $finish;
        end
    end

    initial begin
        logic [7:0] scan [$];
        int         rand_start;
        int         rand_results;
        i_rst_n     <= 1'b0;
        in_if.valid <= 1'b0;
        in_if.data  <= '0;
        restart_scan();

        // CR is written \015 and LF \012 in the texts below.
        scan_rows = '{
            // NUL straight after reset, then a byte marked last while finished.
            '{"", 0, 1'b1, 1'b0, 1'b1, '{LEN_CAP, 1'b0, 1'b0}},
            '{"z", 0, 1'b0, 1'b1, 1'b0, '0},
            // Buffer ends inside the first line.
            '{"Q", 0, 1'b0, 1'b1, 1'b1, '{LEN_CAP, 1'b0, 1'b0}},
            // Empty line with no header before it, then ignored bytes.
            '{"\015\012", 0, 1'b0, 1'b0, 1'b1, '{LEN_CAP, 1'b0, 1'b1}},
            '{"junk", 0, 1'b0, 1'b1, 1'b0, '0},
            '{"Content-Length: 0\015\012\015\012", 0, 1'b0, 1'b0, 1'b1,
              '{32'd21, 1'b1, 1'b1}},
            '{"x", 0, 1'b0, 1'b1, 1'b0, '0},
            // Value saturates; result and reset on the same byte.
            '{"Content-Length: 99999999999\015\012\015\012", 0, 1'b0, 1'b1, 1'b1,
              '{LEN_CAP, 1'b1, 1'b1}},
            // Key with no value.
            '{"Content-Length:\015\012\015\012", 0, 1'b0, 1'b1, 1'b1,
              '{32'd19, 1'b1, 1'b1}},
            '{{"Content-Length: 1 2\015\012content-length: 7\015\012",
               "Content-Length:x 9\015\012Content-Length:: 5\015\012\015\012"},
              0, 1'b0, 1'b1, 1'b0, '0},
            // Lone CR, lone LF, CR CR LF and a stray letter in the value.
            '{"A\015B\012C\015\015\012Content-Length: 3a4\015\012\015\012", 0,
              1'b0, 1'b1, 1'b0, '0},
            // The last key line wins; NUL before the empty line.
            '{"X-Foo: 1\015\012Content-Length: 12\015\012Content-Length: 34\015\012body",
              0, 1'b1, 1'b0, 1'b0, '0},
            '{"z", 0, 1'b0, 1'b1, 1'b0, '0},
            // Unfinished line is neither counted nor used.
            '{"Content-Length: 55\015\012Content-Length: 66", 0, 1'b0, 1'b1, 1'b0, '0},
            '{"Content-Length:  8\015\012Server: Content-Length: 9\015\012\015\012", 0,
              1'b0, 1'b1, 1'b0, '0},
            '{"Content-Length: 4294967295\015\012\015\012", 0, 1'b0, 1'b1, 1'b0, '0},
            // A CR still waiting for its LF when NUL or the last byte arrives.
            '{"ab\015", 0, 1'b1, 1'b0, 1'b0, '0},
            '{"z", 0, 1'b0, 1'b1, 1'b0, '0},
            '{"ab\015", 0, 1'b0, 1'b1, 1'b0, '0},
            '{"\377\200\001 Content-Length: 5\015\012\015\012", 0, 1'b0, 1'b1, 1'b0, '0},
            // A long first line of filler bytes.
            '{"\015\012Content-Length: 10\015\012\015\012", 40, 1'b0, 1'b1, 1'b0, '0}
        };

        tx_idle_pct = 17;
        rx_idle_pct = 67;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed scans.
        foreach (scan_rows[r]) begin
            scan.delete();
            repeat (scan_rows[r].pad) scan.push_back(8'h61);
            add_text(scan, scan_rows[r].txt);
            if (scan_rows[r].nul_end) begin
                scan.push_back(CHR_NUL);
            end
            foreach (scan[i]) begin
                send_byte(scan[i], scan_rows[r].last_end && i == scan.size() - 1,
                          scan_rows[r].typed, scan_rows[r].want);
            end
            scans_sent++;
        end

        // Random responses across the three idling patterns.
        rand_start   = bytes_sent;
        rand_results = results_due;
        while (bytes_sent - rand_start < RANDOM_BYTES ||
               results_due - rand_results < MIN_RAND_SCANS) begin
            if (bytes_sent - rand_start < RANDOM_BYTES / 3) begin
                tx_idle_pct = 17;
                rx_idle_pct = 67;
            end else if (bytes_sent - rand_start < 2 * RANDOM_BYTES / 3) begin
                tx_idle_pct = 67;
                rx_idle_pct = 17;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            build_scan(scan);
            foreach (scan[i]) begin
                send_byte(scan[i], i == scan.size() - 1, 1'b0, '0);
            end
            scans_sent++;
        end

        // Back-to-back one-byte scans while the receiver holds off.
        tx_idle_pct   = 0;
        rx_idle_pct   = 0;
        stall_request = 1'b1;
        repeat (BURST_SCANS) begin
            send_byte(8'($urandom_range(1, 255)), 1'b1, 1'b0, '0);
            scans_sent++;
        end
        in_if.valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        run_done = 1'b1;

        $display("Scanned %0d bytes in %0d responses, %0d results checked, %0d mismatches.",
                 bytes_sent, scans_sent, results_seen, failures);
        $display("Covered lone CR/LF, near-miss keys, saturation, truncation and back-pressure.");
        if (failures == 0) begin
            $display("[http_content_length_scanner] OK");
        end else begin
            $display("[http_content_length_scanner] ERROR");
        end
        $finish;
    end

endmodule
